[rtl/core/pfsp_pkg.sv]
// Shared types, character codes and helpers of the printf spec field parser.
// No dependencies; every other file in rtl/core imports this package.
package pfsp_pkg;

    // Default cap on the spec length that the consumed count tracks
    localparam int unsigned MAX_SPEC_LEN_DEF = 255;

    localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

    // Characters of interest
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_L_LOWER = 8'h6C;
    localparam logic [7:0] CH_L_UPPER = 8'h4C;
    localparam logic [7:0] CH_H_LOWER = 8'h68;

    // Length modifier codes
    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_L     = 3'd1;
    localparam logic [2:0] LEN_LL    = 3'd2;
    localparam logic [2:0] LEN_BIG_L = 3'd3;
    localparam logic [2:0] LEN_H     = 3'd4;
    localparam logic [2:0] LEN_HH    = 3'd5;

    // Bit positions in the flag set
    localparam int FB_MINUS = 0;
    localparam int FB_PLUS  = 1;
    localparam int FB_SPACE = 2;
    localparam int FB_HASH  = 3;
    localparam int FB_ZERO  = 4;

    typedef enum logic [2:0] {
        PH_FLAGS      = 3'd0,
        PH_AFTER_STAR = 3'd1,
        PH_WIDTH_DIG  = 3'd2,
        PH_PREC_DOT   = 3'd3,
        PH_PREC_DIG   = 3'd4,
        PH_LEN_START  = 3'd5,
        PH_LEN_PEEK   = 3'd6,
        PH_DONE       = 3'd7
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [4:0]  flag_bits;
        logic [30:0] width_acc;
        logic [31:0] precision_acc;
        logic        precision_seen;
        logic [7:0]  char_count;
        logic [2:0]  pending_length;
        logic        star_neg;
    } t_state;

    typedef struct packed {
        logic [7:0]         ch;
        logic signed [31:0] star_value;
        logic               first;
    } t_in_item;

    typedef struct packed {
        logic               done_res;
        logic [7:0]         consumed;
        logic               left_align;
        logic               force_plus;
        logic               space_sign;
        logic               alternate_form;
        logic               zero_pad;
        logic [30:0]        field_width;
        logic signed [31:0] precision_value;
        logic               precision_given;
        logic [2:0]         length_code;
    } t_out_item;

    function automatic t_state f_state_reset();
        t_state s;
        s                = '0;
        s.phase          = PH_FLAGS;
        return s;
    endfunction

    // acc * 10 + digit, saturated to 31 bits
    function automatic logic [30:0] f_acc_digit(logic [30:0] acc, logic [7:0] c);
        logic [34:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, c[3:0]};
        return (v > {4'd0, SAT31}) ? SAT31 : v[30:0];
    endfunction

endpackage

[rtl/core/pfsp_step.sv]
// Next-state logic of the spec parser: one character against the current phase.
// Depends on pfsp_pkg for the state type, character codes and digit helper.
module pfsp_step
    import pfsp_pkg::*;
#(
    parameter int unsigned MAX_SPEC_LEN = MAX_SPEC_LEN_DEF
) (
    input  t_state   i_state,
    input  t_in_item i_item,
    output t_state   o_state
);

    localparam logic [7:0] CountCap = (MAX_SPEC_LEN < 255) ? 8'(MAX_SPEC_LEN) : 8'd255;

    function automatic t_state f_count(t_state s);
        t_state r;
        r = s;
        if (r.char_count < CountCap) begin
            r.char_count = r.char_count + 8'd1;
        end
        return r;
    endfunction

    function automatic t_state f_len_start(t_state s, logic [7:0] c);
        t_state r;
        r = s;
        if (c == CH_L_LOWER) begin
            r.pending_length = LEN_L;
            r.phase          = PH_LEN_PEEK;
        end else if (c == CH_H_LOWER) begin
            r.pending_length = LEN_H;
            r.phase          = PH_LEN_PEEK;
        end else begin
            r.pending_length = (c == CH_L_UPPER) ? LEN_BIG_L : LEN_NONE;
            r.phase          = PH_DONE;
        end
        return r;
    endfunction

    function automatic t_state f_prec_start(t_state s, logic [7:0] c);
        t_state r;
        r = s;
        if (c == CH_DOT) begin
            r.precision_seen = 1'b1;
            r.precision_acc  = '0;
            r                = f_count(r);
            r.phase          = PH_PREC_DOT;
        end else begin
            r = f_len_start(r, c);
        end
        return r;
    endfunction

    function automatic t_state f_width_start(t_state s, logic [7:0] c, logic [31:0] star);
        t_state      r;
        logic [31:0] mag;
        r   = s;
        mag = (~star) + 32'd1;
        if (c == CH_STAR) begin
            if (star[31]) begin
                r.width_acc = mag[31] ? SAT31 : mag[30:0];
                r.star_neg  = 1'b1;
            end else begin
                r.width_acc = star[30:0];
                r.star_neg  = 1'b0;
            end
            r       = f_count(r);
            r.phase = PH_AFTER_STAR;
        end else if (c inside {[CH_ZERO:CH_NINE]}) begin
            r.width_acc = f_acc_digit('0, c);
            r           = f_count(r);
            r.phase     = PH_WIDTH_DIG;
        end else begin
            r = f_prec_start(r, c);
        end
        return r;
    endfunction

    t_state      base;
    t_state      nxt;
    logic [7:0]  c;
    logic [31:0] star;
    logic        is_dig;

    always_comb begin
        base   = i_item.first ? f_state_reset() : i_state;
        c      = i_item.ch;
        star   = i_item.star_value;
        is_dig = c inside {[CH_ZERO:CH_NINE]};
        nxt    = base;
        case (base.phase)
            PH_FLAGS: begin
                if (c == CH_MINUS) begin
                    nxt.flag_bits[FB_MINUS] = 1'b1;
                    nxt = f_count(nxt);
                end else if (c == CH_PLUS) begin
                    nxt.flag_bits[FB_PLUS] = 1'b1;
                    nxt = f_count(nxt);
                end else if (c == CH_SPACE) begin
                    nxt.flag_bits[FB_SPACE] = 1'b1;
                    nxt = f_count(nxt);
                end else if (c == CH_HASH) begin
                    nxt.flag_bits[FB_HASH] = 1'b1;
                    nxt = f_count(nxt);
                end else if (c == CH_ZERO) begin
                    nxt.flag_bits[FB_ZERO] = 1'b1;
                    nxt = f_count(nxt);
                end else begin
                    nxt = f_width_start(base, c, star);
                end
            end
            PH_AFTER_STAR: begin
                if (is_dig) begin
                    nxt.star_neg  = 1'b0;
                    nxt.width_acc = f_acc_digit('0, c);
                    nxt           = f_count(nxt);
                    nxt.phase     = PH_WIDTH_DIG;
                end else begin
                    if (base.star_neg) begin
                        nxt.flag_bits[FB_MINUS] = 1'b1;
                    end
                    nxt.star_neg = 1'b0;
                    nxt          = f_prec_start(nxt, c);
                end
            end
            PH_WIDTH_DIG: begin
                if (is_dig) begin
                    nxt.width_acc = f_acc_digit(base.width_acc, c);
                    nxt           = f_count(nxt);
                end else begin
                    nxt = f_prec_start(base, c);
                end
            end
            PH_PREC_DOT: begin
                if (c == CH_STAR) begin
                    nxt.precision_acc = star;
                    nxt               = f_count(nxt);
                    nxt.phase         = PH_LEN_START;
                end else if (is_dig) begin
                    nxt.precision_acc = {1'b0, f_acc_digit('0, c)};
                    nxt               = f_count(nxt);
                    nxt.phase         = PH_PREC_DIG;
                end else begin
                    nxt.precision_acc = '0;
                    nxt               = f_len_start(nxt, c);
                end
            end
            PH_PREC_DIG: begin
                if (is_dig) begin
                    // accumulator stays below 2^31 in this phase
                    nxt.precision_acc = {1'b0, f_acc_digit(base.precision_acc[30:0], c)};
                    nxt               = f_count(nxt);
                end else begin
                    nxt = f_len_start(base, c);
                end
            end
            PH_LEN_START: begin
                nxt = f_len_start(base, c);
            end
            PH_LEN_PEEK: begin
                if (base.pending_length == LEN_L && c == CH_L_LOWER) begin
                    nxt.pending_length = LEN_LL;
                end else if (base.pending_length == LEN_H && c == CH_H_LOWER) begin
                    nxt.pending_length = LEN_HH;
                end
                nxt.phase = PH_DONE;
            end
            default: begin
                nxt = base;
            end
        endcase
        o_state = nxt;
    end

endmodule

[rtl/core/pfsp_skid.sv]
// Output register with one skid entry for the parser's result beats.
// Depends on pfsp_pkg for the result item type.
module pfsp_skid
    import pfsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_item,
    output logic      o_full,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_skid_valid;
    logic      n_skid_valid;
    t_out_item r_skid;
    t_out_item n_skid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || !i_out_stall) begin
            // output slot frees up: drain skid first, else take the new beat
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = i_item;
                n_out_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_item;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[rtl/core/printf_spec_field_parser_top.sv]
// printf conversion spec field parser: one character per input beat, one result beat
// out for each. Input channel: i_in_valid / o_in_stall carrying t_in_item (ch,
// star_value, first). Output channel: o_out_valid / i_out_stall carrying t_out_item.
// A beat is moved at a rising edge where valid is high and stall is low.
//
// Each result beat is registered in the output register, or in the skid entry when
// the receiver stalls. Throughput: one character per cycle while o_in_stall is low;
// the parse state updates as the character is taken, by one pass of the phase logic.
//
// Set first on the opening character of a spec to clear the parsed state. After
// the spec ends (done_res set) further characters without first repeat the final
// result. Parsing starts from the flags phase after reset even without first.
//
// Reset (synchronous, active low) returns the parser to the flags phase and
// empties the output register and skid entry. When the receiver stalls, the
// output beat holds; one more character is still taken into the skid entry, and
// o_in_stall rises only while that entry is occupied.
// Depends on pfsp_pkg, pfsp_step and pfsp_skid.
module printf_spec_field_parser_top
    import pfsp_pkg::*;
#(
    parameter int unsigned MAX_SPEC_LEN = MAX_SPEC_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_state    r_state;
    t_state    n_state;
    t_out_item res_item;
    logic      in_accept;
    logic      skid_full;

    assign o_in_stall = skid_full;
    assign in_accept  = i_in_valid && !skid_full;

    // Phase logic: current state plus this character gives the next state
    pfsp_step #(
        .MAX_SPEC_LEN (MAX_SPEC_LEN)
    ) u_step (
        .i_state (r_state),
        .i_item  (i_in_item),
        .o_state (n_state)
    );

    // Advance the parse state only on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= f_state_reset();
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Result fields come straight from the updated state; a pending negative
    // star width is not yet folded into left_align
    always_comb begin
        res_item.done_res        = (n_state.phase == PH_DONE);
        res_item.consumed        = n_state.char_count;
        res_item.left_align      = n_state.flag_bits[FB_MINUS];
        res_item.force_plus      = n_state.flag_bits[FB_PLUS];
        res_item.space_sign      = n_state.flag_bits[FB_SPACE];
        res_item.alternate_form  = n_state.flag_bits[FB_HASH];
        res_item.zero_pad        = n_state.flag_bits[FB_ZERO];
        res_item.field_width     = n_state.width_acc;
        res_item.precision_value = n_state.precision_acc;
        res_item.precision_given = n_state.precision_seen;
        res_item.length_code     = n_state.pending_length;
    end

    // Hold the result beat; the skid entry absorbs one beat during a stall
    pfsp_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_accept),
        .i_item      (res_item),
        .o_full      (skid_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

[rtl/core/pfsp_checker.sv]
// Port-level checks for the spec parser, attached to the top level by bind.
// Depends on pfsp_pkg for the beat types.
module pfsp_checker
    import pfsp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // A stalled input beat holds until it is taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_item)))
        else $error("input beat changed under stall");

    // A stalled output beat holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("output beat changed under stall");

    // Input backpressure only while an output beat is pending
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    // Without a period the precision reads zero
    a_prec_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.precision_given) |-> (o_out_item.precision_value == 0))
        else $error("precision set without a period");

    // Length code stays within the defined codes
    a_len_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.length_code <= LEN_HH))
        else $error("length code out of range");

endmodule

bind printf_spec_field_parser_top pfsp_checker u_pfsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
